@@ src/grid_axis_locate_and_weights_defines.svh @@
// Assertion macros used by the grid axis locate and weights pipeline.
`ifndef GRID_AXIS_LOCATE_AND_WEIGHTS_DEFINES_SVH
`define GRID_AXIS_LOCATE_AND_WEIGHTS_DEFINES_SVH

`ifndef SYNTHESIS

`define GAL_ASSERT_IMPLY(name, clk_i, rst_ni, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("implication check failed");

`define GAL_ASSERT_NEXT(name, clk_i, rst_ni, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define GAL_ASSERT_IMPLY(name, clk_i, rst_ni, ante, cons)

`define GAL_ASSERT_NEXT(name, clk_i, rst_ni, ante, cons)

`endif

`endif

@@ src/gal_pkg.sv @@
// Shared constants and types of the grid axis locate and weights block.
package gal_pkg;

	localparam int FRAC_BITS     = 16;
	localparam int STENCIL_SLOTS = 4;
	localparam int COORD_W       = 32;
	localparam int COUNT_W       = 16;
	localparam int START_W       = 16;
	localparam int WEIGHT_W      = FRAC_BITS + 2;
	localparam int DATA_W        = 32;
	localparam int ADDR_W        = 4;

	localparam logic [1:0] MODE_NEAREST = 2'd0;
	localparam logic [1:0] MODE_LINEAR  = 2'd1;
	localparam logic [1:0] MODE_CUBIC   = 2'd2;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_ORIGIN = 2'd1;
	localparam logic [1:0] REG_SCALE  = 2'd2;
	localparam logic [1:0] REG_COUNT  = 2'd3;

	localparam logic [31:0]        RST_SCALE = 32'h0001_0000;
	localparam logic [COUNT_W-1:0] RST_COUNT = 16'd2;

	typedef logic signed [WEIGHT_W-1:0] weight_t;
	typedef logic [START_W-1:0]         start_t;

	typedef struct packed {
		logic [1:0]                 mode;
		logic signed [COORD_W-1:0]  origin;
		logic [31:0]                scale;
		logic [COUNT_W-1:0]         count;
	} gal_cfg_t;

endpackage

@@ src/gal_if.sv @@
// Stream interfaces for query coordinates and stencil results.
interface gal_in_if import gal_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] x_coord;

	modport source(output valid, x_coord, input ready);
	modport sink(input valid, x_coord, output ready);
endinterface

interface gal_out_if import gal_pkg::*; ();
	logic    valid;
	logic    ready;
	start_t  window_start;
	weight_t weight_a;
	weight_t weight_b;
	weight_t weight_c;
	weight_t weight_d;
	logic    was_clamped;

	modport source(output valid, window_start, weight_a, weight_b, weight_c, weight_d,
		was_clamped, input ready);
	modport sink(input valid, window_start, weight_a, weight_b, weight_c, weight_d,
		was_clamped, output ready);
endinterface

@@ src/gal_pipe.sv @@
// Eight-stage locate and weight pipeline with per-stage valid bits.
`include "grid_axis_locate_and_weights_defines.svh"

module gal_pipe import gal_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  gal_cfg_t  cfg,
	gal_in_if.sink    coord,
	gal_out_if.source result
);

	localparam int NSTG  = 8;
	localparam int RAW_W = COUNT_W + FRAC_BITS;
	localparam int Q_W   = 64 - FRAC_BITS;
	localparam int S_W   = FRAC_BITS + 1;
	localparam int NUM_W = FRAC_BITS + 5;

	localparam logic [RAW_W:0]             HALF_R  = (RAW_W + 1)'(1) << (FRAC_BITS - 1);
	localparam logic [2*S_W-1:0]           HALF_P  = (2 * S_W)'(1) << (FRAC_BITS - 1);
	localparam logic [S_W-1:0]             ONE_S   = S_W'(1) << FRAC_BITS;
	localparam logic signed [NUM_W-1:0]    TWO_ONE = NUM_W'(1) << (FRAC_BITS + 1);
	localparam logic signed [NUM_W-1:0]    NUM_ONE = NUM_W'(1);
	localparam weight_t                    ONE_W   = WEIGHT_W'(1) << FRAC_BITS;

	// round half up of v/2 equals floor((v+1)/2)
	function automatic weight_t half_up(input logic signed [NUM_W-1:0] v);
		logic signed [NUM_W-1:0] a;
		a = v + NUM_ONE;
		return WEIGHT_W'(a >>> 1);
	endfunction

	// handshake chain
	logic [NSTG:1]   vld_q;
	logic [NSTG+1:1] en;

	always_comb begin
		en[NSTG+1] = result.ready;
		for (int k = NSTG; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign coord.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= coord.valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// node count views
	logic [COUNT_W-1:0] n_eff;
	logic [COUNT_W-1:0] nm1;
	logic               ge2;
	logic               ge4;
	logic [COUNT_W-1:0] maxbase;
	logic [COUNT_W-1:0] maxstart;

	always_comb begin
		n_eff    = (cfg.count == '0) ? COUNT_W'(1) : cfg.count;
		nm1      = n_eff - COUNT_W'(1);
		ge2      = n_eff >= COUNT_W'(2);
		ge4      = n_eff >= COUNT_W'(STENCIL_SLOTS);
		maxbase  = ge2 ? n_eff - COUNT_W'(2) : '0;
		maxstart = n_eff - COUNT_W'(STENCIL_SLOTS);
	end

	// stage 1: offset from origin
	logic signed [COORD_W:0] diff_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			diff_s1 <= {coord.x_coord[COORD_W-1], coord.x_coord}
				- {cfg.origin[COORD_W-1], cfg.origin};
		end
	end

	// stage 2: scale
	logic [63:0] prod_c;
	logic [63:0] prod_s2;
	logic        neg_s2;
	logic        under_s2;

	assign prod_c = diff_s1[COORD_W-1:0] * cfg.scale;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			prod_s2  <= prod_c;
			neg_s2   <= diff_s1[COORD_W];
			under_s2 <= cfg.scale != '0;
		end
	end

	// stage 3: clamp to [0, top]
	logic [Q_W-1:0]   q_c;
	logic [RAW_W-1:0] top_c;
	logic [RAW_W-1:0] raw_s3;
	logic             clamp_s3;

	assign q_c   = prod_s2[63:FRAC_BITS];
	assign top_c = {nm1, {FRAC_BITS{1'b0}}};

	always_ff @(posedge clk) begin
		if (en[3]) begin
			if (neg_s2) begin
				raw_s3   <= '0;
				clamp_s3 <= under_s2;
			end else if (q_c > Q_W'(top_c)) begin
				raw_s3   <= top_c;
				clamp_s3 <= 1'b1;
			end else begin
				raw_s3   <= q_c[RAW_W-1:0];
				clamp_s3 <= 1'b0;
			end
		end
	end

	// stage 4: base cell, fraction, nearest node
	logic [COUNT_W-1:0] base0_c;
	logic [RAW_W:0]     near_c;
	start_t             near_s4;
	logic [COUNT_W-1:0] base_s4;
	logic [S_W-1:0]     s_s4;
	logic               clamp_s4;

	assign base0_c = raw_s3[RAW_W-1:FRAC_BITS];
	assign near_c  = (RAW_W + 1)'(raw_s3) + HALF_R;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			near_s4  <= near_c[FRAC_BITS +: START_W];
			clamp_s4 <= clamp_s3;
			if (base0_c > maxbase) begin
				base_s4 <= maxbase;
				s_s4    <= ge2 ? ONE_S : '0;
			end else begin
				base_s4 <= base0_c;
				s_s4    <= S_W'(raw_s3[FRAC_BITS-1:0]);
			end
		end
	end

	// stage 5: s squared, cubic window placement
	logic [2*S_W-1:0]   sq_c;
	logic [S_W-1:0]     s2_s5;
	logic [S_W-1:0]     s_s5;
	start_t             near_s5;
	logic [COUNT_W-1:0] base_s5;
	start_t             cstart_s5;
	logic [1:0]         slot_s5;
	logic               clamp_s5;

	assign sq_c = s_s4 * s_s4 + HALF_P;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			s2_s5    <= sq_c[FRAC_BITS +: S_W];
			s_s5     <= s_s4;
			near_s5  <= near_s4;
			base_s5  <= base_s4;
			clamp_s5 <= clamp_s4;
			if (!ge4) begin
				cstart_s5 <= '0;
				slot_s5   <= base_s4[1:0];
			end else if (base_s4 == '0) begin
				cstart_s5 <= '0;
				slot_s5   <= 2'd0;
			end else if (base_s4 - COUNT_W'(1) > maxstart) begin
				cstart_s5 <= maxstart;
				slot_s5   <= 2'd2;
			end else begin
				cstart_s5 <= base_s4 - COUNT_W'(1);
				slot_s5   <= 2'd1;
			end
		end
	end

	// stage 6: s cubed
	logic [2*S_W-1:0]   cu_c;
	logic [S_W-1:0]     s3_s6;
	logic [S_W-1:0]     s2_s6;
	logic [S_W-1:0]     s_s6;
	start_t             near_s6;
	logic [COUNT_W-1:0] base_s6;
	start_t             cstart_s6;
	logic [1:0]         slot_s6;
	logic               clamp_s6;

	assign cu_c = s2_s5 * s_s5 + HALF_P;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			s3_s6     <= cu_c[FRAC_BITS +: S_W];
			s2_s6     <= s2_s5;
			s_s6      <= s_s5;
			near_s6   <= near_s5;
			base_s6   <= base_s5;
			cstart_s6 <= cstart_s5;
			slot_s6   <= slot_s5;
			clamp_s6  <= clamp_s5;
		end
	end

	// stage 7: Keys numerators
	logic signed [NUM_W-1:0] sx_c;
	logic signed [NUM_W-1:0] s2x_c;
	logic signed [NUM_W-1:0] s3x_c;
	logic signed [NUM_W-1:0] num0_s7;
	logic signed [NUM_W-1:0] num1_s7;
	logic signed [NUM_W-1:0] num2_s7;
	logic signed [NUM_W-1:0] num3_s7;
	logic [S_W-1:0]          s_s7;
	start_t                  near_s7;
	logic [COUNT_W-1:0]      base_s7;
	start_t                  cstart_s7;
	logic [1:0]              slot_s7;
	logic                    clamp_s7;

	assign sx_c  = $signed(NUM_W'(s_s6));
	assign s2x_c = $signed(NUM_W'(s2_s6));
	assign s3x_c = $signed(NUM_W'(s3_s6));

	always_ff @(posedge clk) begin
		if (en[7]) begin
			num0_s7   <= (s2x_c <<< 1) - s3x_c - sx_c;
			num1_s7   <= (s3x_c <<< 1) + s3x_c - (s2x_c <<< 2) - s2x_c + TWO_ONE;
			num2_s7   <= (s2x_c <<< 2) + sx_c - (s3x_c <<< 1) - s3x_c;
			num3_s7   <= s3x_c - s2x_c;
			s_s7      <= s_s6;
			near_s7   <= near_s6;
			base_s7   <= base_s6;
			cstart_s7 <= cstart_s6;
			slot_s7   <= slot_s6;
			clamp_s7  <= clamp_s6;
		end
	end

	// stage 8: pick weights per mode, result register
	weight_t w_c [STENCIL_SLOTS];
	start_t  start_c;
	weight_t sw_c;
	weight_t rw_c;
	start_t  start_s8;
	weight_t w_s8 [STENCIL_SLOTS];
	logic    clamp_s8;

	assign sw_c = $signed(WEIGHT_W'(s_s7));
	assign rw_c = ONE_W - sw_c;

	always_comb begin
		for (int k = 0; k < STENCIL_SLOTS; k++) begin
			w_c[k] = '0;
		end
		start_c = base_s7;
		unique case (cfg.mode)
			MODE_NEAREST: begin
				start_c = near_s7;
				w_c[0]  = ONE_W;
			end
			MODE_CUBIC: begin
				start_c = cstart_s7;
				if (ge4 && slot_s7 == 2'd1) begin
					w_c[0] = half_up(num0_s7);
					w_c[1] = half_up(num1_s7);
					w_c[2] = half_up(num2_s7);
					w_c[3] = half_up(num3_s7);
				end else begin
					case (slot_s7)
						2'd0: begin
							w_c[0] = rw_c;
							w_c[1] = sw_c;
						end
						2'd1: begin
							w_c[1] = rw_c;
							w_c[2] = sw_c;
						end
						2'd2: begin
							w_c[2] = rw_c;
							w_c[3] = sw_c;
						end
						default: begin
							w_c[3] = rw_c;
						end
					endcase
				end
			end
			default: begin
				w_c[0] = rw_c;
				w_c[1] = sw_c;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			start_s8 <= start_c;
			w_s8     <= w_c;
			clamp_s8 <= clamp_s7;
		end
	end

	assign result.valid        = vld_q[NSTG];
	assign result.window_start = start_s8;
	assign result.weight_a     = w_s8[0];
	assign result.weight_b     = w_s8[1];
	assign result.weight_c     = w_s8[2];
	assign result.weight_d     = w_s8[3];
	assign result.was_clamped  = clamp_s8;

	`GAL_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, coord.valid && coord.ready, vld_q[1])
	`GAL_ASSERT_IMPLY(a_frac_le_one, clk, arst_n, vld_q[4], s_s4 <= ONE_S)
	`GAL_ASSERT_IMPLY(a_slot_in_window, clk, arst_n, vld_q[5], slot_s5 != 2'd3)
	`GAL_ASSERT_IMPLY(a_full_stall_blocks, clk, arst_n, (&vld_q) && !result.ready, !coord.ready)

endmodule

@@ src/grid_axis_locate_and_weights.sv @@
// Stages: offset, scale, clamp, locate, square, cube, numerators, weight pick (output reg).
// Throughput: one coordinate per cycle while result.ready is high; the stages advance
// independently, so a stalled output only holds full stages and bubbles still fill.
// The scale multiply and the two cubic power multiplies each own a stage.
// Reset clears all stage valid bits and loads the register reset values
// (linear mode, origin 0, scale 1.0, two nodes).
module grid_axis_locate_and_weights import gal_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	gal_in_if.sink            coord,
	gal_out_if.source         result
);

	gal_cfg_t   cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= MODE_LINEAR;
			cfg_q.origin <= '0;
			cfg_q.scale  <= RST_SCALE;
			cfg_q.count  <= RST_COUNT;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MODE:   cfg_q.mode   <= pwdata[1:0];
				REG_ORIGIN: cfg_q.origin <= $signed(pwdata);
				REG_SCALE:  cfg_q.scale  <= pwdata;
				REG_COUNT:  cfg_q.count  <= pwdata[COUNT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MODE:   prdata = DATA_W'(cfg_q.mode);
			REG_ORIGIN: prdata = cfg_q.origin;
			REG_SCALE:  prdata = cfg_q.scale;
			REG_COUNT:  prdata = DATA_W'(cfg_q.count);
		endcase
	end

	gal_pipe u_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.coord  (coord),
		.result (result)
	);

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the grid axis locate and stencil weights block.
module tb;
	import gal_pkg::*;

	typedef struct packed {
		start_t  window_start;
		weight_t weight_a;
		weight_t weight_b;
		weight_t weight_c;
		weight_t weight_d;
		logic    was_clamped;
	} stencil_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	gal_in_if  coord_if();
	gal_out_if result_if();

	grid_axis_locate_and_weights u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coord   (coord_if),
		.result  (result_if)
	);

	// shadow copy of the axis registers
	logic [1:0]         cfg_mode   = MODE_LINEAR;
	logic signed [31:0] cfg_origin = '0;
	logic [31:0]        cfg_scale  = RST_SCALE;
	logic [15:0]        cfg_count  = RST_COUNT;

	stencil_t stencil_q[$];
	int       mismatch_count = 0;
	bit       idle_on = 1'b1;

	always #4 clk = ~clk;

	initial begin
		#(8 * 400000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// halve with rounding half toward plus infinity
	function automatic longint halve_round_up(longint v);
		longint a;
		a = v + 1;
		if (a >= 0) return a >>> 1;
		return -((-a + 1) >>> 1);
	endfunction

	function automatic stencil_t predict_stencil(logic signed [31:0] x);
		longint     one, half, n, diff, base, s, s2, s3, start, maxbase, maxstart, slot;
		longint     w[4];
		logic [63:0] mag, prod, top, raw;
		logic       clamped;
		stencil_t   res;
		one = longint'(1) << FRAC_BITS;
		half = longint'(1) << (FRAC_BITS - 1);
		n = (cfg_count == 0) ? 1 : longint'(cfg_count);
		top = 64'(n - 1) << FRAC_BITS;
		diff = longint'(x) - longint'(cfg_origin);
		clamped = 1'b0;
		raw = '0;
		start = 0;
		for (int k = 0; k < 4; k++) w[k] = 0;

		if (diff < 0) begin
			mag = 64'(-diff);
			prod = mag * {32'd0, cfg_scale};
			clamped = (prod != 0);
		end else begin
			prod = (64'(diff) * {32'd0, cfg_scale}) >> FRAC_BITS;
			if (prod > top) begin
				clamped = 1'b1;
				raw = top;
			end else begin
				raw = prod;
			end
		end

		if (cfg_mode == MODE_NEAREST) begin
			start = longint'((raw + 64'(half)) >> FRAC_BITS);
			w[0] = one;
		end else begin
			maxbase = (n >= 2) ? n - 2 : 0;
			base = longint'(raw >> FRAC_BITS);
			if (base > maxbase) begin
				base = maxbase;
				s = (n >= 2) ? one : 0;
			end else begin
				s = longint'(raw & 64'(one - 1));
			end
			if (cfg_mode != MODE_CUBIC) begin
				start = base;
				w[0] = one - s;
				w[1] = s;
			end else begin
				maxstart = n - STENCIL_SLOTS;
				start = (n >= STENCIL_SLOTS) ? base - 1 : 0;
				if (start < 0) start = 0;
				else if (start > maxstart) start = (maxstart > 0) ? maxstart : 0;
				slot = base - start;
				if (n >= STENCIL_SLOTS && slot == 1) begin
					s2 = (s * s + half) >>> FRAC_BITS;
					s3 = (s2 * s + half) >>> FRAC_BITS;
					w[0] = halve_round_up(-s3 + 2 * s2 - s);
					w[1] = halve_round_up(3 * s3 - 5 * s2 + 2 * one);
					w[2] = halve_round_up(-3 * s3 + 4 * s2 + s);
					w[3] = halve_round_up(s3 - s2);
				end else if (slot >= 0 && slot < STENCIL_SLOTS) begin
					w[slot] = one - s;
					if (slot + 1 < STENCIL_SLOTS) w[slot + 1] = s;
				end
			end
		end

		res.window_start = start[START_W-1:0];
		res.weight_a = w[0][WEIGHT_W-1:0];
		res.weight_b = w[1][WEIGHT_W-1:0];
		res.weight_c = w[2][WEIGHT_W-1:0];
		res.weight_d = w[3][WEIGHT_W-1:0];
		res.was_clamped = clamped;
		return res;
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		stencil_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (stencil_q.size() == 0) begin
				$error("result transaction with no pending query");
				mismatch_count++;
			end else begin
				want = stencil_q.pop_front();
				check_field("window_start", want.window_start, result_if.window_start);
				check_field("weight_a", want.weight_a, result_if.weight_a);
				check_field("weight_b", want.weight_b, result_if.weight_b);
				check_field("weight_c", want.weight_c, result_if.weight_c);
				check_field("weight_d", want.weight_d, result_if.weight_d);
				check_field("was_clamped", want.was_clamped, result_if.was_clamped);
			end
		end
	end

	// result sink: random stall before each transaction while idle_on is set
	initial begin : result_sink
		int stall;
		result_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, 16) : 0;
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!result_if.valid);
		end
	end

	// leaves valid high on return; the caller sends again or drains in the same step
	task automatic send_coord(input logic signed [31:0] x);
		int gap;
		gap = idle_on ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			coord_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		coord_if.valid <= 1'b1;
		coord_if.x_coord <= x;
		do @(posedge clk); while (!coord_if.ready);
		stencil_q.push_back(predict_stencil(x));
	endtask

	task automatic drain_results();
		coord_if.valid <= 1'b0;
		while (stencil_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_MODE:   cfg_mode = value[1:0];
			REG_ORIGIN: cfg_origin = value;
			REG_SCALE:  cfg_scale = value;
			REG_COUNT:  cfg_count = value[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic test_reset_config();
		send_coord(32'h0000_0000);
		send_coord(32'h0000_8000);
		send_coord(32'h0001_8000);
		send_coord(32'hFFFF_FFFF);
		drain_results();
	endtask

	task automatic test_nearest_rounding();
		write_reg(REG_MODE, {30'd0, MODE_NEAREST});
		write_reg(REG_COUNT, 32'd5);
		send_coord(32'h0000_7FFF);
		send_coord(32'h0000_8000);
		send_coord(32'h0001_8000);
		send_coord(32'h0004_8000);
		drain_results();
	endtask

	task automatic test_linear_edges();
		write_reg(REG_MODE, {30'd0, MODE_LINEAR});
		write_reg(REG_COUNT, 32'd1);
		send_coord(32'h0001_0000);
		send_coord(32'h0000_0000);
		drain_results();
		write_reg(REG_COUNT, 32'd0);
		send_coord(32'h0000_8000);
		drain_results();
		// unused mode code with junk in the upper bits
		write_reg(REG_MODE, 32'hFFFF_FFFF);
		write_reg(REG_COUNT, 32'd6);
		send_coord(32'h0002_4000);
		drain_results();
	endtask

	task automatic test_cubic_windows();
		write_reg(REG_MODE, {30'd0, MODE_CUBIC});
		write_reg(REG_COUNT, 32'd8);
		send_coord(32'h0000_4000);
		send_coord(32'h0003_8000);
		send_coord(32'h0003_0000);
		send_coord(32'h0006_C000);
		send_coord(32'h0009_0000);
		drain_results();
		write_reg(REG_COUNT, 32'd3);
		send_coord(32'h0001_8000);
		drain_results();
		write_reg(REG_COUNT, 32'd4);
		send_coord(32'h0001_4000);
		drain_results();
	endtask

	task automatic test_zero_scale();
		write_reg(REG_MODE, {30'd0, MODE_LINEAR});
		write_reg(REG_SCALE, 32'd0);
		send_coord(32'h8000_0000);
		send_coord(32'h7FFF_FFFF);
		drain_results();
	endtask

	task automatic test_range_extremes();
		write_reg(REG_MODE, {30'd0, MODE_CUBIC});
		write_reg(REG_ORIGIN, 32'h8000_0000);
		write_reg(REG_SCALE, 32'hFFFF_FFFF);
		write_reg(REG_COUNT, 32'h0000_FFFF);
		send_coord(32'h7FFF_FFFF);
		send_coord(32'h8000_0000);
		send_coord(32'h8000_0001);
		drain_results();
		write_reg(REG_MODE, {30'd0, MODE_NEAREST});
		send_coord(32'h7FFF_FFFF);
		drain_results();
		write_reg(REG_ORIGIN, 32'h7FFF_FFFF);
		send_coord(32'h8000_0000);
		drain_results();
	endtask

	task automatic test_random_queries();
		longint             span, r;
		longint             n_eff;
		logic signed [31:0] x;
		for (int phase = 0; phase < 10; phase++) begin
			write_reg(REG_MODE, {$urandom} & 32'hFFFF_FFFC | 32'($urandom_range(0, 3)));
			case ($urandom_range(0, 5))
				0: write_reg(REG_ORIGIN, 32'h8000_0000);
				1: write_reg(REG_ORIGIN, 32'h7FFF_FFFF);
				default: write_reg(REG_ORIGIN, $urandom);
			endcase
			case ($urandom_range(0, 7))
				0: write_reg(REG_SCALE, 32'd0);
				1: write_reg(REG_SCALE, 32'hFFFF_FFFF);
				default: write_reg(REG_SCALE, $urandom_range(32'h400, 32'h40_0000));
			endcase
			case ($urandom_range(0, 7))
				0: write_reg(REG_COUNT, $urandom_range(0, 3));
				1: write_reg(REG_COUNT, 32'h0000_FFFF);
				2: write_reg(REG_COUNT, $urandom);
				default: write_reg(REG_COUNT, $urandom_range(4, 24));
			endcase
			n_eff = (cfg_count == 0) ? 1 : longint'(cfg_count);
			span = (n_eff + 2) << FRAC_BITS;
			for (int i = 0; i < 200; i++) begin
				if (i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
				// aim most queries at positions from one node below the grid to two above its last node
				r = longint'($urandom) % span - (longint'(1) << FRAC_BITS);
				case ($urandom_range(0, 7))
					0: r = r & ~longint'(16'hFFFF);
					1: r = (r & ~longint'(16'hFFFF)) | longint'(16'h8000);
					default: ;
				endcase
				if (cfg_scale == 0 || $urandom_range(0, 3) == 0)
					x = $urandom;
				else
					x = cfg_origin + 32'((r <<< FRAC_BITS) / longint'(cfg_scale));
				send_coord(x);
			end
			drain_results();
		end
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		coord_if.valid <= 1'b0;
		coord_if.x_coord <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_config();
		test_nearest_rounding();
		test_linear_edges();
		test_cubic_windows();
		test_zero_scale();
		test_range_extremes();
		test_random_queries();

		drain_results();
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+src
src/gal_pkg.sv
src/gal_if.sv
src/gal_pipe.sv
src/grid_axis_locate_and_weights.sv
tb/tb.sv
